// ===== design/mlqd_pkg.sv =====
package mlqd_pkg;

  // Default widths for the top level parameters
  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int DEF_LLR_WIDTH    = 24;

  // Level magnitudes are Q1.12, at most 4424, so 14 signed bits
  localparam int LVL_W      = 14;
  // Level slots per axis: sign bit and a two-bit magnitude index
  localparam int SLOTS      = 8;
  localparam int LLR_NUM    = 6;
  // Product carries 36 fraction bits, LLR carries 8
  localparam int FRAC_SHIFT = 28;

  typedef logic [1:0] mode_t;
  typedef logic signed [LVL_W-1:0] level_t;

  localparam mode_t MODE_QPSK  = 2'd0;
  localparam mode_t MODE_QAM16 = 2'd1;
  localparam mode_t MODE_QAM64 = 2'd2;

  // Reserved mode code decodes as 64-QAM
  function automatic mode_t eff_mode(input mode_t m);
    mode_t r;
    case (m)
      MODE_QPSK:  r = MODE_QPSK;
      MODE_QAM16: r = MODE_QAM16;
      default:    r = MODE_QAM64;
    endcase
    return r;
  endfunction

  // Magnitude of level index a, a = 0 is the outermost level
  function automatic level_t level_mag(input mode_t m, input logic [1:0] a);
    level_t r;
    unique case (m)
      MODE_QPSK:  r = LVL_W'(2896);
      MODE_QAM16: r = a[0] ? LVL_W'(1295) : LVL_W'(3886);
      default: begin
        case (a)
          2'd0:    r = LVL_W'(4424);
          2'd1:    r = LVL_W'(3160);
          2'd2:    r = LVL_W'(1896);
          default: r = LVL_W'(632);
        endcase
      end
    endcase
    return r;
  endfunction

  // Signed level of a slot: slot[2] is the sign, slot[1:0] the magnitude index
  function automatic level_t slot_level(input mode_t m, input logic [2:0] slot);
    level_t mag;
    mag = level_mag(m, slot[1:0]);
    return slot[2] ? level_t'(-mag) : mag;
  endfunction

  // Slot exists in this constellation
  function automatic logic slot_used(input mode_t m, input logic [2:0] slot);
    logic r;
    unique case (m)
      MODE_QPSK:  r = (slot[1:0] == 2'd0);
      MODE_QAM16: r = (slot[1] == 1'b0);
      default:    r = 1'b1;
    endcase
    return r;
  endfunction

  // Label bit of a slot for bit pair 'pair' (pair 0 is the sign)
  function automatic logic slot_bit(input mode_t m, input logic [1:0] pair,
                                    input logic [2:0] slot);
    logic [1:0] g;
    logic       r;
    g = slot[1:0] ^ (slot[1:0] >> 1);
    r = 1'b0;
    if (pair == 2'd0) begin
      r = slot[2];
    end else begin
      case (m)
        MODE_QAM16: r = (pair == 2'd1) ? g[0] : 1'b0;
        MODE_QAM64: r = (pair == 2'd1) ? g[1] : ((pair == 2'd2) ? g[0] : 1'b0);
        default:    r = 1'b0;
      endcase
    end
    return r;
  endfunction

  // Number of label bits per carrier
  function automatic logic [2:0] label_bits(input mode_t m);
    logic [2:0] r;
    unique case (m)
      MODE_QPSK:  r = 3'd2;
      MODE_QAM16: r = 3'd4;
      default:    r = 3'd6;
    endcase
    return r;
  endfunction

endpackage

// ===== design/max_log_qam_soft_demapper.sv =====
// Max-log soft demapper for Gray-labelled square QAM (QPSK, 16-QAM, 64-QAM).
// Input channel in_*: one equalized carrier per beat (I, Q and reliability,
// all signed Q3.12). Result channel out_*: one beat per carrier with six
// Q15.8 LLRs and num_bits; LLRs at or above num_bits are zero.
// Config channel cfg_*: cfg_constellation_mode selects the constellation,
// always ready; write it only while no carrier is in flight. Code 3 acts
// as 64-QAM. Reset selects QPSK.
// Pipeline stages, in order: level distances, nearest-level select,
// distance-difference multiply, weight multiply, round/saturate output.
// Throughput: one carrier per cycle while out_ready is high; every stage
// is a register stage with its own valid bit.
// Stall: a stage advances when it is empty or the stage after it advances,
// so a held out_ready fills the bubbles first and then drops in_ready; no
// beat is lost or repeated. Reset empties the pipeline; out_valid is low
// and in_ready high right after reset.
module max_log_qam_soft_demapper import mlqd_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int LLR_WIDTH    = DEF_LLR_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_constellation_mode,
  // carriers in
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_carrier_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_carrier_q,
  input  logic signed [SAMPLE_WIDTH-1:0] in_carrier_weight,
  // LLRs out
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [LLR_WIDTH-1:0]    out_llr_0,
  output logic signed [LLR_WIDTH-1:0]    out_llr_1,
  output logic signed [LLR_WIDTH-1:0]    out_llr_2,
  output logic signed [LLR_WIDTH-1:0]    out_llr_3,
  output logic signed [LLR_WIDTH-1:0]    out_llr_4,
  output logic signed [LLR_WIDTH-1:0]    out_llr_5,
  output logic [2:0]                     out_num_bits
);

  localparam int XW = (SAMPLE_WIDTH > LVL_W) ? SAMPLE_WIDTH : LVL_W;
  localparam int MW = LVL_W + 3 + XW;

  mode_t mode_r, mode_nxt;

  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_vld_r;
  logic s1_vld_nxt, s2_vld_nxt, s3_vld_nxt, s4_vld_nxt, out_vld_nxt;
  logic en1, en2, en3, en4, en5;

  logic [1:0][SLOTS-1:0][XW-1:0]     s1_dist;
  logic [1:0][SAMPLE_WIDTH-1:0]      s1_x, s2_x;
  logic [SAMPLE_WIDTH-2:0]           s1_wmag, s2_wmag, s3_wmag;
  mode_t                             s1_mode, s2_mode, s3_mode;
  logic [LLR_NUM-1:0][LVL_W-1:0]     s2_l0, s2_l1;
  logic [LLR_NUM-1:0][MW-1:0]        s3_diff;
  logic [LLR_NUM-1:0][LLR_WIDTH-1:0] llr;

  // Mode register
  assign cfg_ready = 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_valid) begin
      mode_nxt = cfg_constellation_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_QPSK;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // Advance a stage when it is empty or its successor advances
  assign en5      = !out_vld_r || out_ready;
  assign en4      = !s4_vld_r || en5;
  assign en3      = !s3_vld_r || en4;
  assign en2      = !s2_vld_r || en3;
  assign en1      = !s1_vld_r || en2;
  assign in_ready = en1;

  always_comb begin
    s1_vld_nxt  = en1 ? in_valid : s1_vld_r;
    s2_vld_nxt  = en2 ? s1_vld_r : s2_vld_r;
    s3_vld_nxt  = en3 ? s2_vld_r : s3_vld_r;
    s4_vld_nxt  = en4 ? s3_vld_r : s4_vld_r;
    out_vld_nxt = en5 ? s4_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      s2_vld_r  <= s2_vld_nxt;
      s3_vld_r  <= s3_vld_nxt;
      s4_vld_r  <= s4_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  mlqd_dist #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_dist (
    .clk    (clk),
    .en     (en1),
    .mode_i (mode_r),
    .x_i    ({in_carrier_q, in_carrier_i}),
    .w_i    (in_carrier_weight),
    .dist_o (s1_dist),
    .x_o    (s1_x),
    .wmag_o (s1_wmag),
    .mode_o (s1_mode)
  );

  mlqd_select #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_select (
    .clk    (clk),
    .en     (en2),
    .dist_i (s1_dist),
    .x_i    (s1_x),
    .wmag_i (s1_wmag),
    .mode_i (s1_mode),
    .l0_o   (s2_l0),
    .l1_o   (s2_l1),
    .x_o    (s2_x),
    .wmag_o (s2_wmag),
    .mode_o (s2_mode)
  );

  mlqd_metric #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_metric (
    .clk    (clk),
    .en     (en3),
    .l0_i   (s2_l0),
    .l1_i   (s2_l1),
    .x_i    (s2_x),
    .wmag_i (s2_wmag),
    .mode_i (s2_mode),
    .diff_o (s3_diff),
    .wmag_o (s3_wmag),
    .mode_o (s3_mode)
  );

  mlqd_scale #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .LLR_WIDTH   (LLR_WIDTH)
  ) u_scale (
    .clk        (clk),
    .en_mul     (en4),
    .en_out     (en5),
    .diff_i     (s3_diff),
    .wmag_i     (s3_wmag),
    .mode_i     (s3_mode),
    .llr_o      (llr),
    .num_bits_o (out_num_bits)
  );

  assign out_valid = out_vld_r;
  assign out_llr_0 = llr[0];
  assign out_llr_1 = llr[1];
  assign out_llr_2 = llr[2];
  assign out_llr_3 = llr[3];
  assign out_llr_4 = llr[4];
  assign out_llr_5 = llr[5];

  // Result beats carry a legal bit count
  a_num_bits_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_num_bits == label_bits(MODE_QPSK) ||
                   out_num_bits == label_bits(MODE_QAM16) ||
                   out_num_bits == label_bits(MODE_QAM64)))
    else $error("illegal bit count on result beat");

  // Unused LLRs of a QPSK beat are zero
  a_qpsk_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_num_bits == label_bits(MODE_QPSK)) |->
      (out_llr_2 == '0 && out_llr_3 == '0 && out_llr_4 == '0 && out_llr_5 == '0))
    else $error("unused LLR not zero on QPSK beat");

  // Unused LLRs of a 16-QAM beat are zero
  a_qam16_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_num_bits == label_bits(MODE_QAM16)) |->
      (out_llr_4 == '0 && out_llr_5 == '0))
    else $error("unused LLR not zero on 16-QAM beat");

  // An empty output register never blocks the input
  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output register empty");

endmodule

// ===== design/mlqd_dist.sv =====
module mlqd_dist import mlqd_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  mode_t                                  mode_i,
  input  logic [1:0][SAMPLE_WIDTH-1:0]           x_i,
  input  logic [SAMPLE_WIDTH-1:0]                w_i,
  output logic [1:0][SLOTS-1:0][((SAMPLE_WIDTH > LVL_W) ? SAMPLE_WIDTH : LVL_W)-1:0] dist_o,
  output logic [1:0][SAMPLE_WIDTH-1:0]           x_o,
  output logic [SAMPLE_WIDTH-2:0]                wmag_o,
  output mode_t                                  mode_o
);

  localparam int XW = (SAMPLE_WIDTH > LVL_W) ? SAMPLE_WIDTH : LVL_W;

  logic [1:0][SLOTS-1:0][XW-1:0] dist_nxt, dist_r;
  logic [1:0][SAMPLE_WIDTH-1:0]  x_r;
  logic [SAMPLE_WIDTH-2:0]       wmag_nxt, wmag_r;
  mode_t                         mode_nxt, mode_r;

  // Distance from each axis coordinate to every level slot
  always_comb begin
    logic signed [XW:0] d;
    level_t             lvl;
    mode_nxt = eff_mode(mode_i);
    for (int ax = 0; ax < 2; ax++) begin
      for (int s = 0; s < SLOTS; s++) begin
        lvl = slot_level(mode_nxt, 3'(s));
        d = $signed({{(XW+1-SAMPLE_WIDTH){x_i[ax][SAMPLE_WIDTH-1]}}, x_i[ax]})
          - $signed({{(XW+1-LVL_W){lvl[LVL_W-1]}}, lvl});
        dist_nxt[ax][s] = d[XW] ? XW'(-d) : d[XW-1:0];
      end
    end
    // Clamp negative reliability to zero
    wmag_nxt = w_i[SAMPLE_WIDTH-1] ? '0 : w_i[SAMPLE_WIDTH-2:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= dist_nxt;
      x_r    <= x_i;
      wmag_r <= wmag_nxt;
      mode_r <= mode_nxt;
    end
  end

  assign dist_o = dist_r;
  assign x_o    = x_r;
  assign wmag_o = wmag_r;
  assign mode_o = mode_r;

endmodule

// ===== design/mlqd_select.sv =====
module mlqd_select import mlqd_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [1:0][SLOTS-1:0][((SAMPLE_WIDTH > LVL_W) ? SAMPLE_WIDTH : LVL_W)-1:0] dist_i,
  input  logic [1:0][SAMPLE_WIDTH-1:0]           x_i,
  input  logic [SAMPLE_WIDTH-2:0]                wmag_i,
  input  mode_t                                  mode_i,
  output logic [LLR_NUM-1:0][LVL_W-1:0]          l0_o,
  output logic [LLR_NUM-1:0][LVL_W-1:0]          l1_o,
  output logic [1:0][SAMPLE_WIDTH-1:0]           x_o,
  output logic [SAMPLE_WIDTH-2:0]                wmag_o,
  output mode_t                                  mode_o
);

  localparam int XW = (SAMPLE_WIDTH > LVL_W) ? SAMPLE_WIDTH : LVL_W;

  logic [LLR_NUM-1:0][LVL_W-1:0] l0_nxt, l1_nxt, l0_r, l1_r;
  logic [1:0][SAMPLE_WIDTH-1:0]  x_r;
  logic [SAMPLE_WIDTH-2:0]       wmag_r;
  mode_t                         mode_r;

  // Pick the nearest zero level and the nearest one level for each bit
  always_comb begin
    logic [XW-1:0] best0, best1;
    logic          have0, have1;
    level_t        lv0, lv1;
    logic [2:0]    slot;
    logic          b;
    for (int k = 0; k < LLR_NUM; k++) begin
      best0 = '0;
      best1 = '0;
      have0 = 1'b0;
      have1 = 1'b0;
      lv0   = '0;
      lv1   = '0;
      for (int s = 0; s < SLOTS; s++) begin
        slot = 3'(s);
        b    = slot_bit(mode_i, 2'(k / 2), slot);
        if (slot_used(mode_i, slot)) begin
          if (!b) begin
            if (!have0 || (dist_i[k % 2][s] < best0)) begin
              best0 = dist_i[k % 2][s];
              lv0   = slot_level(mode_i, slot);
            end
            have0 = 1'b1;
          end else begin
            if (!have1 || (dist_i[k % 2][s] < best1)) begin
              best1 = dist_i[k % 2][s];
              lv1   = slot_level(mode_i, slot);
            end
            have1 = 1'b1;
          end
        end
      end
      l0_nxt[k] = lv0;
      l1_nxt[k] = lv1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l0_r   <= l0_nxt;
      l1_r   <= l1_nxt;
      x_r    <= x_i;
      wmag_r <= wmag_i;
      mode_r <= mode_i;
    end
  end

  assign l0_o   = l0_r;
  assign l1_o   = l1_r;
  assign x_o    = x_r;
  assign wmag_o = wmag_r;
  assign mode_o = mode_r;

endmodule

// ===== design/mlqd_metric.sv =====
module mlqd_metric import mlqd_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [LLR_NUM-1:0][LVL_W-1:0]          l0_i,
  input  logic [LLR_NUM-1:0][LVL_W-1:0]          l1_i,
  input  logic [1:0][SAMPLE_WIDTH-1:0]           x_i,
  input  logic [SAMPLE_WIDTH-2:0]                wmag_i,
  input  mode_t                                  mode_i,
  output logic [LLR_NUM-1:0][LVL_W+3+((SAMPLE_WIDTH > LVL_W) ? SAMPLE_WIDTH : LVL_W)-1:0] diff_o,
  output logic [SAMPLE_WIDTH-2:0]                wmag_o,
  output mode_t                                  mode_o
);

  localparam int XW = (SAMPLE_WIDTH > LVL_W) ? SAMPLE_WIDTH : LVL_W;
  localparam int AW = LVL_W + 1;
  localparam int BW = XW + 2;
  localparam int MW = AW + BW;

  logic [LLR_NUM-1:0][MW-1:0] diff_nxt, diff_r;
  logic [SAMPLE_WIDTH-2:0]    wmag_r;
  mode_t                      mode_r;

  // min0 - min1 = (l0 - l1) * (l0 + l1 - 2x), exact with 24 fraction bits
  always_comb begin
    logic signed [MW-1:0] a_ext, b_ext, l0_ext, l1_ext, x_ext;
    for (int k = 0; k < LLR_NUM; k++) begin
      l0_ext = $signed({{(MW-LVL_W){l0_i[k][LVL_W-1]}}, l0_i[k]});
      l1_ext = $signed({{(MW-LVL_W){l1_i[k][LVL_W-1]}}, l1_i[k]});
      x_ext  = $signed({{(MW-SAMPLE_WIDTH){x_i[k % 2][SAMPLE_WIDTH-1]}}, x_i[k % 2]});
      a_ext  = l0_ext - l1_ext;
      b_ext  = l0_ext + l1_ext - (x_ext <<< 1);
      diff_nxt[k] = a_ext * b_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= diff_nxt;
      wmag_r <= wmag_i;
      mode_r <= mode_i;
    end
  end

  assign diff_o = diff_r;
  assign wmag_o = wmag_r;
  assign mode_o = mode_r;

endmodule

// ===== design/mlqd_scale.sv =====
module mlqd_scale import mlqd_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int LLR_WIDTH    = DEF_LLR_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   en_mul,
  input  logic                                   en_out,
  input  logic [LLR_NUM-1:0][LVL_W+3+((SAMPLE_WIDTH > LVL_W) ? SAMPLE_WIDTH : LVL_W)-1:0] diff_i,
  input  logic [SAMPLE_WIDTH-2:0]                wmag_i,
  input  mode_t                                  mode_i,
  output logic [LLR_NUM-1:0][LLR_WIDTH-1:0]      llr_o,
  output logic [2:0]                             num_bits_o
);

  localparam int XW   = (SAMPLE_WIDTH > LVL_W) ? SAMPLE_WIDTH : LVL_W;
  localparam int MW   = LVL_W + 3 + XW;
  localparam int PW   = MW + SAMPLE_WIDTH;
  localparam int SUMW = (PW + 1 > LLR_WIDTH) ? PW + 1 : LLR_WIDTH + 1;

  localparam logic signed [SUMW-1:0] RND     = SUMW'(1) <<< (FRAC_SHIFT - 1);
  localparam logic signed [SUMW-1:0] LLR_MAX =
    {{(SUMW-LLR_WIDTH+1){1'b0}}, {(LLR_WIDTH-1){1'b1}}};
  localparam logic signed [SUMW-1:0] LLR_MIN = ~LLR_MAX;

  logic [LLR_NUM-1:0][PW-1:0]        prod_nxt, prod_r;
  mode_t                             mode_r;
  logic [LLR_NUM-1:0][LLR_WIDTH-1:0] llr_nxt, llr_r;
  logic [2:0]                        num_bits_nxt, num_bits_r;

  // Weight the distance difference, 36 fraction bits
  always_comb begin
    logic signed [PW-1:0] d_ext, w_ext;
    w_ext = $signed({{(PW-SAMPLE_WIDTH+1){1'b0}}, wmag_i});
    for (int k = 0; k < LLR_NUM; k++) begin
      d_ext = $signed({{(PW-MW){diff_i[k][MW-1]}}, diff_i[k]});
      prod_nxt[k] = d_ext * w_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_r <= prod_nxt;
      mode_r <= mode_i;
    end
  end

  // Round half up to 8 fraction bits, saturate, drop unused bits
  always_comb begin
    logic signed [SUMW-1:0] sum, sh;
    num_bits_nxt = label_bits(mode_r);
    for (int k = 0; k < LLR_NUM; k++) begin
      sum = $signed({{(SUMW-PW){prod_r[k][PW-1]}}, prod_r[k]}) + RND;
      sh  = sum >>> FRAC_SHIFT;
      if (3'(k) >= num_bits_nxt) begin
        llr_nxt[k] = '0;
      end else if (sh > LLR_MAX) begin
        llr_nxt[k] = LLR_MAX[LLR_WIDTH-1:0];
      end else if (sh < LLR_MIN) begin
        llr_nxt[k] = LLR_MIN[LLR_WIDTH-1:0];
      end else begin
        llr_nxt[k] = sh[LLR_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      llr_r      <= llr_nxt;
      num_bits_r <= num_bits_nxt;
    end
  end

  assign llr_o      = llr_r;
  assign num_bits_o = num_bits_r;

endmodule
